### hw/rtl/pru_pkg.sv
// Package for the pixel replicate upscaler: payload structs, register indexes,
// field widths and default limits. Depends on nothing.
package pru_pkg;

  localparam int SCALE_W    = 5;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int COLOR_W    = 8;
  localparam int PAD_W      = 2;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_SCALE = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } in_req_t;

  typedef struct packed {
    logic               accepted;
    logic [COLOR_W-1:0] out_blue;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_red;
    logic               end_of_line;
    logic [PAD_W-1:0]   pad_bytes;
    logic               end_of_frame;
  } out_req_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic             accepted;
    logic             pixel;
    logic             end_of_line;
    logic [PAD_W-1:0] pad_bytes;
    logic             end_of_frame;
  } stage_flags_t;

endpackage

### hw/rtl/pru_stream_if.sv
// Valid/ready channel carrying one request of payload type T.
// Depends on nothing; the payload types come from pru_pkg at instantiation.
interface pru_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/pixel_replicate_upscaler_top.sv
// An accepted request reaches the result through the stage-one register and then the output register.
// Throughput: one request per cycle while the output is not stalled; the line store has one write and one
// registered read port, and an output register decouples the result side.
// Reset is synchronous and active low: counters clear, the block starts in
// filling mode, and all three limits return to 1. The line store is not cleared.
// Depends on pru_pkg and pru_stream_if.
module pixel_replicate_upscaler_top #(
  parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
  input  logic         clk,
  input  logic         rst_n,
  pru_stream_if.sink   in_if,
  pru_stream_if.source out_if,
  pru_stream_if.sink   cfg_if
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PXW = 3 * pru_pkg::COLOR_W;

  logic [pru_pkg::SCALE_W-1:0] n_m1_r;
  logic [1:0]                  n_lo_r;
  logic [AW-1:0]               w_m1_r;
  logic [1:0]                  w_lo_r;
  logic [pru_pkg::ROW_W-1:0]   h_m1_r;

  logic [AW-1:0]               fill_col_r;
  logic [AW-1:0]               src_col_r;
  logic [pru_pkg::SCALE_W-1:0] sub_r;
  logic [pru_pkg::SCALE_W-1:0] rep_r;
  logic [pru_pkg::ROW_W-1:0]   row_r;
  logic                        emitting_r;

  logic [PXW-1:0] mem [MAX_WIDTH];
  logic [PXW-1:0] rd_q_r;

  logic                  s1_valid_r;
  pru_pkg::stage_flags_t s1_r;
  pru_pkg::stage_flags_t s1_nxt;
  logic                  out_valid_r;
  pru_pkg::out_req_t     out_r;

  logic s1_adv;
  logic in_fire;
  logic cfg_fire;
  logic is_read;
  logic do_write;
  logic do_read;
  logic sub_last;
  logic col_last;
  logic rep_last;
  logic row_last;
  logic [1:0] pad_w;

  logic [pru_pkg::SCALE_W-1:0] n_m1_nxt;
  logic [1:0]                  n_lo_nxt;
  logic [AW-1:0]               w_m1_nxt;
  logic [1:0]                  w_lo_nxt;
  logic [pru_pkg::ROW_W-1:0]   h_m1_nxt;

  assign s1_adv       = !out_valid_r || out_if.ready;
  assign in_if.ready  = !s1_valid_r || s1_adv;
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_fire     = cfg_if.valid;

  assign is_read  = (in_if.data.cmd == pru_pkg::CMD_READ);
  assign do_write = in_fire && !is_read && !emitting_r;
  assign do_read  = in_fire && is_read && emitting_r;

  assign sub_last = (sub_r == n_m1_r);
  assign col_last = (src_col_r == w_m1_r);
  assign rep_last = (rep_r == n_m1_r);
  assign row_last = (row_r == h_m1_r);
  assign pad_w    = 2'(n_lo_r * w_lo_r);

  // Clamp each register value into its legal range when it is written.
  always_comb begin
    int sv;
    int wv;
    int hv;
    sv = int'(cfg_if.data.data[pru_pkg::SCALE_W-1:0]);
    wv = int'(cfg_if.data.data[pru_pkg::WIDTH_W-1:0]);
    hv = int'(cfg_if.data.data[pru_pkg::HEIGHT_W-1:0]);
    if (sv == 0) sv = 1;
    if (sv > MAX_SCALE) sv = MAX_SCALE;
    if (wv == 0) wv = 1;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    if (hv == 0) hv = 1;
    if (hv > pru_pkg::MAX_HEIGHT) hv = pru_pkg::MAX_HEIGHT;
    n_m1_nxt = pru_pkg::SCALE_W'(sv - 1);
    n_lo_nxt = 2'(sv);
    w_m1_nxt = AW'(wv - 1);
    w_lo_nxt = 2'(wv);
    h_m1_nxt = pru_pkg::ROW_W'(hv - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_m1_r <= '0;
      n_lo_r <= 2'd1;
      w_m1_r <= '0;
      w_lo_r <= 2'd1;
      h_m1_r <= '0;
    end else if (cfg_fire) begin
      case (cfg_if.data.index)
        pru_pkg::CFG_SCALE: begin
          n_m1_r <= n_m1_nxt;
          n_lo_r <= n_lo_nxt;
        end
        pru_pkg::CFG_WIDTH: begin
          w_m1_r <= w_m1_nxt;
          w_lo_r <= w_lo_nxt;
        end
        pru_pkg::CFG_HEIGHT: begin
          h_m1_r <= h_m1_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_col_r <= '0;
      src_col_r  <= '0;
      sub_r      <= '0;
      rep_r      <= '0;
      row_r      <= '0;
      emitting_r <= 1'b0;
    end else if (cfg_fire && (cfg_if.data.index != pru_pkg::CFG_UNUSED)) begin
      fill_col_r <= '0;
      src_col_r  <= '0;
      sub_r      <= '0;
      rep_r      <= '0;
      row_r      <= '0;
      emitting_r <= 1'b0;
    end else if (do_write) begin
      if (fill_col_r == w_m1_r) begin
        fill_col_r <= '0;
        src_col_r  <= '0;
        sub_r      <= '0;
        rep_r      <= '0;
        emitting_r <= 1'b1;
      end else begin
        fill_col_r <= fill_col_r + 1'b1;
      end
    end else if (do_read) begin
      if (sub_last) begin
        sub_r <= '0;
        if (col_last) begin
          src_col_r <= '0;
          if (rep_last) begin
            rep_r      <= '0;
            emitting_r <= 1'b0;
            row_r      <= row_last ? '0 : row_r + 1'b1;
          end else begin
            rep_r <= rep_r + 1'b1;
          end
        end else begin
          src_col_r <= src_col_r + 1'b1;
        end
      end else begin
        sub_r <= sub_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[fill_col_r] <= {in_if.data.red, in_if.data.green, in_if.data.blue};
    end
    if (do_read) begin
      rd_q_r <= mem[src_col_r];
    end
  end

  always_comb begin
    s1_nxt              = '0;
    s1_nxt.accepted     = do_write || do_read;
    s1_nxt.pixel        = do_read;
    s1_nxt.end_of_line  = do_read && sub_last && col_last;
    s1_nxt.pad_bytes    = (do_read && sub_last && col_last) ? pad_w : '0;
    s1_nxt.end_of_frame = do_read && sub_last && col_last && rep_last && row_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_r.accepted     <= s1_r.accepted;
      out_r.out_blue     <= s1_r.pixel ? rd_q_r[7:0] : '0;
      out_r.out_green    <= s1_r.pixel ? rd_q_r[15:8] : '0;
      out_r.out_red      <= s1_r.pixel ? rd_q_r[23:16] : '0;
      out_r.end_of_line  <= s1_r.end_of_line;
      out_r.pad_bytes    <= s1_r.pad_bytes;
      out_r.end_of_frame <= s1_r.end_of_frame;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

endmodule
